// ===== hdl/p2ba_pkg.sv =====
// Shared constants, types and helper functions of the power-of-two bucket allocator.
package p2ba_pkg;

    localparam int HEAP_BYTES   = 1048576;
    localparam int NUM_CLASSES  = 21;
    localparam int SPLIT_CUTOFF = 12;
    localparam int HEADER_BYTES = 16;
    localparam int ALIGN_BYTES  = 8;
    localparam int HEAP_LIMIT_RESET = 1048576;

    localparam int SIZE_W    = 21;
    localparam int ADDR_W    = 20;
    localparam int GRANULES  = HEAP_BYTES / ALIGN_BYTES;
    localparam int GRAN_W    = $clog2(GRANULES);
    localparam int ALIGN_SH  = $clog2(ALIGN_BYTES);
    localparam int CLS_W     = $clog2(NUM_CLASSES);
    localparam int REQ_CLS_W = $clog2((NUM_CLASSES > SIZE_W) ? NUM_CLASSES + 1 : SIZE_W + 1);
    localparam int CNT_W     = $clog2(SPLIT_CUTOFF + 3);
    localparam int QB_W      = SIZE_W + 1;
    localparam int QG_W      = QB_W - ALIGN_SH;
    localparam int TOT_W     = QB_W + CNT_W;

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_RESIZE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic              has_next;
        logic [GRAN_W-1:0] next;
    } hdr_t;

    // Smallest class c >= 1 with n <= 2^c: the bit length of n - 1, but at least 1.
    function automatic logic [REQ_CLS_W-1:0] size_class(input logic [SIZE_W-1:0] n);
        logic [SIZE_W-1:0]    m;
        logic [REQ_CLS_W-1:0] c;
        m = (n == '0) ? '0 : n - 1'b1;
        c = REQ_CLS_W'(1);
        for (int i = 1; i < SIZE_W; i++) begin
            if (m[i]) begin
                c = REQ_CLS_W'(i + 1);
            end
        end
        return c;
    endfunction

    // Header plus class size, rounded up to the alignment, counted in granules.
    function automatic logic [QG_W-1:0] quantum_gran(input logic [CLS_W-1:0] c);
        logic [QB_W-1:0] b;
        b = QB_W'(HEADER_BYTES + ALIGN_BYTES - 1) + (QB_W'(1) << c);
        return QG_W'(b >> ALIGN_SH);
    endfunction

    // Number of quanta carved at once for a class.
    function automatic logic [CNT_W-1:0] carve_count(input logic [CLS_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (32'(c) < SPLIT_CUTOFF) begin
            r = CNT_W'(SPLIT_CUTOFF + 2) - CNT_W'(c);
        end else begin
            r = CNT_W'(1);
        end
        return r;
    endfunction

    // Data offset of the block whose header starts at granule g.
    function automatic logic [ADDR_W-1:0] gran_to_addr(input logic [GRAN_W-1:0] g);
        logic [ADDR_W+ALIGN_SH:0] a;
        a = ((ADDR_W + ALIGN_SH + 1)'(g) << ALIGN_SH) + (ADDR_W + ALIGN_SH + 1)'(HEADER_BYTES);
        return a[ADDR_W-1:0];
    endfunction

endpackage

// ===== hdl/pow2_bucket_allocator.sv =====
// Power-of-two segregated free-list allocator: sequencer, header and mark memories, class heads.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-----------------------------------------------
//  s_       | in        | s_valid / s_ready  | s_action, s_req_size, s_block_addr
//  m_       | out       | m_valid / m_ready  | m_status, m_result_addr, m_moved, m_copy_bytes
//  cfg_     | in        | cfg_wr_en          | cfg_wr_data (heap limit in bytes)
//
// An allocation popped from a free list passes the decode, alloc, pop and response states; a
// fresh carve passes decode, alloc and check, then writes its quanta one at a time through the
// single header-memory write port; a free passes decode, look, push and response, and a moving
// resize adds the push after the allocation.
// After reset the in-use marks are cleared one granule a cycle over all 131072 granules, while
// s_ready stays low. A finished result waits in the output register while m_ready is low;
// the sequencer holds in its response state until the output register is free.
module pow2_bucket_allocator
    import p2ba_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic [SIZE_W-1:0] s_req_size,
    input  logic [ADDR_W-1:0] s_block_addr,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [ADDR_W-1:0] m_result_addr,
    output logic              m_moved,
    output logic [SIZE_W-1:0] m_copy_bytes
);

    // One-hot sequencer states.
    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_DECODE = 10'b00_0000_0100,
        S_LOOK   = 10'b00_0000_1000,
        S_ALLOC  = 10'b00_0001_0000,
        S_POP    = 10'b00_0010_0000,
        S_CHECK  = 10'b00_0100_0000,
        S_CARVE  = 10'b00_1000_0000,
        S_PUSH   = 10'b01_0000_0000,
        S_RESP   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Control registers.
    logic [GRAN_W-1:0] clr_reg, clr_next;
    logic [SIZE_W-1:0] break_reg, break_next;
    logic [SIZE_W-1:0] heap_limit_reg;
    logic              m_valid_reg, m_valid_next;

    // Item registers.
    logic [1:0]           act_reg, act_next;
    logic [SIZE_W-1:0]    req_reg, req_next;
    logic [ADDR_W-1:0]    baddr_reg, baddr_next;
    logic [REQ_CLS_W-1:0] req_cls_reg, req_cls_next;
    logic                 has_old_reg, has_old_next;
    logic [GRAN_W-1:0]    old_g_reg, old_g_next;
    logic [CLS_W-1:0]     old_cls_reg, old_cls_next;
    logic [TOT_W-1:0]     total_reg, total_next;
    logic [QG_W-1:0]      qg_reg, qg_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [GRAN_W-1:0]    carve_g_reg, carve_g_next;

    // Result being built and the output register.
    logic [1:0]        res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic              res_moved_reg, res_moved_next;
    logic [SIZE_W-1:0] res_copy_reg, res_copy_next;
    logic [1:0]        m_status_reg, m_status_next;
    logic [ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic              m_moved_reg, m_moved_next;
    logic [SIZE_W-1:0] m_copy_reg, m_copy_next;

    // Class heads: valid bits cleared by reset, granule indexes written before use.
    logic [NUM_CLASSES-1:0] head_valid_reg;
    logic [GRAN_W-1:0]      head_idx_reg [NUM_CLASSES];
    logic                   head_we;
    logic [CLS_W-1:0]       head_sel;
    logic                   head_wvalid;
    logic [GRAN_W-1:0]      head_widx;

    // Header memory and in-use mark memory, one write and one registered read each.
    hdr_t              hdr_mem [GRANULES];
    logic              mark_mem [GRANULES];
    hdr_t              hdr_rd_reg;
    logic              mark_rd_reg;
    logic              hdr_we;
    logic [GRAN_W-1:0] hdr_waddr;
    hdr_t              hdr_wdata;
    logic              mark_we;
    logic [GRAN_W-1:0] mark_waddr;
    logic              mark_wdata;
    logic [GRAN_W-1:0] rd_addr;

    // Address checks and arithmetic of the shared datapath.
    logic [ADDR_W-1:0]  hoff;
    logic [GRAN_W-1:0]  baddr_gran;
    logic               baddr_ok;
    logic [SIZE_W-1:0]  limit;
    logic [TOT_W:0]     brk_sum;
    logic [QG_W:0]      g_step;
    logic [CLS_W-1:0]   cur_cls;

    assign hoff       = baddr_reg - ADDR_W'(HEADER_BYTES);
    assign baddr_gran = hoff[ALIGN_SH +: GRAN_W];
    assign baddr_ok   = ((ADDR_W + 1)'(baddr_reg) >= (ADDR_W + 1)'(HEADER_BYTES))
                     && (hoff[ALIGN_SH-1:0] == '0)
                     && ((ADDR_W + 1)'(hoff) < (ADDR_W + 1)'(HEAP_BYTES));
    assign limit      = ((SIZE_W + 1)'(heap_limit_reg) < (SIZE_W + 1)'(HEAP_BYTES))
                     ? heap_limit_reg : SIZE_W'(HEAP_BYTES);
    assign brk_sum    = (TOT_W + 1)'(break_reg) + (TOT_W + 1)'(total_reg);
    assign g_step     = (QG_W + 1)'(carve_g_reg) + (QG_W + 1)'(qg_reg);
    assign cur_cls    = req_cls_reg[CLS_W-1:0];

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        break_next      = break_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        act_next        = act_reg;
        req_next        = req_reg;
        baddr_next      = baddr_reg;
        req_cls_next    = req_cls_reg;
        has_old_next    = has_old_reg;
        old_g_next      = old_g_reg;
        old_cls_next    = old_cls_reg;
        total_next      = total_reg;
        qg_next         = qg_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        carve_g_next    = carve_g_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_moved_next  = res_moved_reg;
        res_copy_next   = res_copy_reg;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;
        m_moved_next    = m_moved_reg;
        m_copy_next     = m_copy_reg;

        head_we     = 1'b0;
        head_sel    = cur_cls;
        head_wvalid = 1'b0;
        head_widx   = carve_g_reg;
        hdr_we      = 1'b0;
        hdr_waddr   = carve_g_reg;
        hdr_wdata   = '0;
        mark_we     = 1'b0;
        mark_waddr  = carve_g_reg;
        mark_wdata  = 1'b0;
        rd_addr     = baddr_gran;

        unique case (state_reg)
            S_CLEAR: begin
                mark_we    = 1'b1;
                mark_waddr = clr_reg;
                mark_wdata = 1'b0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == GRAN_W'(GRANULES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    act_next        = s_action;
                    req_next        = s_req_size;
                    baddr_next      = s_block_addr;
                    has_old_next    = 1'b0;
                    res_status_next = ST_OK;
                    res_addr_next   = '0;
                    res_moved_next  = 1'b0;
                    res_copy_next   = '0;
                    state_next      = S_DECODE;
                end
            end
            S_DECODE: begin
                // The mark and header reads for block_addr start here.
                req_cls_next = size_class(req_reg);
                rd_addr      = baddr_gran;
                if (act_reg == ACT_ALLOC) begin
                    state_next = S_ALLOC;
                end else if (act_reg == ACT_FREE || act_reg == ACT_RESIZE) begin
                    if (baddr_reg == '0) begin
                        state_next = (act_reg == ACT_RESIZE) ? S_ALLOC : S_RESP;
                    end else if (!baddr_ok) begin
                        res_status_next = ST_BAD;
                        state_next      = S_RESP;
                    end else begin
                        state_next = S_LOOK;
                    end
                end else begin
                    state_next = S_RESP;
                end
            end
            S_LOOK: begin
                if (!mark_rd_reg || 32'(hdr_rd_reg.cls) >= NUM_CLASSES) begin
                    res_status_next = ST_BAD;
                    state_next      = S_RESP;
                end else begin
                    has_old_next = 1'b1;
                    old_g_next   = baddr_gran;
                    old_cls_next = hdr_rd_reg.cls;
                    if (act_reg == ACT_FREE) begin
                        state_next = S_PUSH;
                    end else if (req_cls_reg <= REQ_CLS_W'(hdr_rd_reg.cls)) begin
                        res_addr_next = baddr_reg;
                        state_next    = S_RESP;
                    end else begin
                        state_next = S_ALLOC;
                    end
                end
            end
            S_ALLOC: begin
                if (32'(req_cls_reg) >= NUM_CLASSES) begin
                    res_status_next = ST_NOMEM;
                    state_next      = S_RESP;
                end else if (head_valid_reg[cur_cls]) begin
                    rd_addr      = head_idx_reg[cur_cls];
                    carve_g_next = head_idx_reg[cur_cls];
                    state_next   = S_POP;
                end else begin
                    qg_next    = quantum_gran(cur_cls);
                    cnt_next   = carve_count(cur_cls);
                    total_next = ((TOT_W)'(quantum_gran(cur_cls)) << ALIGN_SH)
                               * TOT_W'(carve_count(cur_cls));
                    state_next = S_CHECK;
                end
            end
            S_POP: begin
                if (mark_rd_reg) begin
                    res_status_next = ST_BAD;
                    state_next      = S_RESP;
                end else begin
                    head_we       = 1'b1;
                    head_wvalid   = hdr_rd_reg.has_next;
                    head_widx     = hdr_rd_reg.next;
                    mark_we       = 1'b1;
                    mark_waddr    = carve_g_reg;
                    mark_wdata    = 1'b1;
                    res_addr_next = gran_to_addr(carve_g_reg);
                    state_next    = has_old_reg ? S_PUSH : S_RESP;
                end
            end
            S_CHECK: begin
                if (brk_sum > (TOT_W + 1)'(limit)) begin
                    res_status_next = ST_NOMEM;
                    state_next      = S_RESP;
                end else begin
                    break_next    = brk_sum[SIZE_W-1:0];
                    carve_g_next  = break_reg[ALIGN_SH +: GRAN_W];
                    res_addr_next = ADDR_W'((SIZE_W + 1)'(break_reg) + (SIZE_W + 1)'(HEADER_BYTES));
                    k_next        = '0;
                    state_next    = S_CARVE;
                end
            end
            S_CARVE: begin
                // One quantum a cycle; the first is granted, the rest form the free list.
                hdr_we             = 1'b1;
                hdr_waddr          = carve_g_reg;
                hdr_wdata.cls      = cur_cls;
                hdr_wdata.has_next = (k_reg != '0) && ((k_reg + 1'b1) < cnt_reg);
                hdr_wdata.next     = g_step[GRAN_W-1:0];
                mark_we            = 1'b1;
                mark_waddr         = carve_g_reg;
                mark_wdata         = (k_reg == '0);
                if (k_reg == '0 && cnt_reg > CNT_W'(1)) begin
                    head_we     = 1'b1;
                    head_wvalid = 1'b1;
                    head_widx   = g_step[GRAN_W-1:0];
                end
                carve_g_next = g_step[GRAN_W-1:0];
                k_next       = k_reg + 1'b1;
                if ((k_reg + 1'b1) == cnt_reg) begin
                    state_next = has_old_reg ? S_PUSH : S_RESP;
                end
            end
            S_PUSH: begin
                head_sel           = old_cls_reg;
                hdr_we             = 1'b1;
                hdr_waddr          = old_g_reg;
                hdr_wdata.cls      = old_cls_reg;
                hdr_wdata.has_next = head_valid_reg[old_cls_reg];
                hdr_wdata.next     = head_idx_reg[old_cls_reg];
                mark_we            = 1'b1;
                mark_waddr         = old_g_reg;
                mark_wdata         = 1'b0;
                head_we            = 1'b1;
                head_wvalid        = 1'b1;
                head_widx          = old_g_reg;
                if (act_reg == ACT_RESIZE) begin
                    res_moved_next = 1'b1;
                    res_copy_next  = SIZE_W'(1) << old_cls_reg;
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = (res_status_reg == ST_OK) ? res_addr_reg : '0;
                    m_moved_next  = res_moved_reg;
                    m_copy_next   = res_copy_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            break_reg      <= '0;
            heap_limit_reg <= SIZE_W'(HEAP_LIMIT_RESET);
            m_valid_reg    <= 1'b0;
            head_valid_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            break_reg   <= break_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                heap_limit_reg <= cfg_wr_data;
            end
            if (head_we) begin
                head_valid_reg[head_sel] <= head_wvalid;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        req_reg        <= req_next;
        baddr_reg      <= baddr_next;
        req_cls_reg    <= req_cls_next;
        has_old_reg    <= has_old_next;
        old_g_reg      <= old_g_next;
        old_cls_reg    <= old_cls_next;
        total_reg      <= total_next;
        qg_reg         <= qg_next;
        cnt_reg        <= cnt_next;
        k_reg          <= k_next;
        carve_g_reg    <= carve_g_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_moved_reg  <= res_moved_next;
        res_copy_reg   <= res_copy_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
        m_moved_reg    <= m_moved_next;
        m_copy_reg     <= m_copy_next;
        if (head_we) begin
            head_idx_reg[head_sel] <= head_widx;
        end
    end

    // Header memory.
    always_ff @(posedge aclk) begin
        if (hdr_we) begin
            hdr_mem[hdr_waddr] <= hdr_wdata;
        end
        hdr_rd_reg <= hdr_mem[rd_addr];
    end

    // In-use mark memory.
    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rd_reg <= mark_mem[rd_addr];
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_result_addr = m_addr_reg;
    assign m_moved       = m_moved_reg;
    assign m_copy_bytes  = m_copy_reg;

    // The carve walk never writes more quanta than the class carves.
    a_carve_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CARVE) |-> (k_reg < cnt_reg))
        else $error("carve index ran past the quantum count");

    // The bump pointer never passes the heap size.
    a_break_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (SIZE_W + 1)'(break_reg) <= (SIZE_W + 1)'(HEAP_BYTES))
        else $error("bump pointer beyond heap");

    // A failed request grants no address.
    a_fail_no_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_result_addr == '0))
        else $error("address granted with failing status");

    // A moved block reports success and a nonzero copy size.
    a_moved_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_moved) |-> (m_status == ST_OK && m_copy_bytes != '0))
        else $error("moved result without success or copy size");

    // One item at a time: the sequencer leaves idle after each transfer.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while busy");

endmodule
